[rtl/resource_lock_with_waiter_handoff_core_defines.svh]
// assertion macros shared by the checker of the lock manager core
// no dependencies; taken in by `include in files that assert
`ifndef RESOURCE_LOCK_WITH_WAITER_HANDOFF_CORE_DEFINES_SVH
`define RESOURCE_LOCK_WITH_WAITER_HANDOFF_CORE_DEFINES_SVH

// clocked assertion with reset disable and a fixed message
`define RLWH_ASSERT_MSG(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion with a generic message
`define RLWH_ASSERT(lbl, clk, rst_n, prop) \
  `RLWH_ASSERT_MSG(lbl, clk, rst_n, prop, "rlwh assertion failed")

`endif

[rtl/rlwh_pkg.sv]
// package of the lock manager core: widths, command and status codes, cell command
// no dependencies; used by rlwh_cell, the top level and the checker
`default_nettype none

package rlwh_pkg;

  // default number of resources and processes
  localparam int unsigned NumSlotsDef = 16;

  // field widths
  localparam int unsigned ResW    = 4;
  localparam int unsigned PidW    = 4;
  localparam int unsigned StatusW = 3;

  // command codes
  localparam logic CMD_ACQUIRE = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  // status codes
  localparam logic [StatusW-1:0] ST_GRANTED      = 3'd0;
  localparam logic [StatusW-1:0] ST_WAITING      = 3'd1;
  localparam logic [StatusW-1:0] ST_REFUSED      = 3'd2;
  localparam logic [StatusW-1:0] ST_RELEASED     = 3'd3;
  localparam logic [StatusW-1:0] ST_BAD_INDEX    = 3'd4;
  localparam logic [StatusW-1:0] ST_RELEASE_FREE = 3'd5;

  // command broadcast from the controller to every cell
  typedef struct packed {
    logic            take;  // mark resource res as held
    logic            give;  // mark resource res as free
    logic            hold;  // mark process pid as waiting on res
    logic [ResW-1:0] res;
    logic [PidW-1:0] pid;
  } cell_cmd_t;

endpackage

`default_nettype wire

[rtl/rlwh_cell.sv]
// one cell of the lock manager chain: free bit of one resource, waiter entry of one process
// depends on rlwh_pkg; the search token enters from the lower neighbor
`default_nettype none

module rlwh_cell #(
  parameter int unsigned CellIdx = 0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rlwh_pkg::cell_cmd_t cmd_i,
  input  logic                tok_i,
  output logic                tok_o,
  output logic                hit_o,
  output logic                free_sel_o,
  output logic                wait_sel_o
);
  import rlwh_pkg::*;

  logic            free_q, free_d;
  logic            wv_q, wv_d;
  logic [ResW-1:0] wres_q, wres_d;
  logic            tok_q;
  logic            is_res;
  logic            is_pid;

  // address decode against this cell's position
  assign is_res = (32'(cmd_i.res) == CellIdx);
  assign is_pid = (32'(cmd_i.pid) == CellIdx);

  // search: claim the token when this process waits on the released resource
  assign hit_o = tok_q & wv_q & (wres_q == cmd_i.res);
  assign tok_o = tok_q & ~hit_o;

  // lookups for the controller
  assign free_sel_o = free_q & is_res;
  assign wait_sel_o = wv_q & is_pid;

  // next state of the entries
  always_comb begin
    free_d = free_q;
    wv_d   = wv_q;
    wres_d = wres_q;
    if (cmd_i.take && is_res) begin
      free_d = 1'b0;
    end else if (cmd_i.give && is_res) begin
      free_d = 1'b1;
    end
    if (hit_o) begin
      wv_d = 1'b0;
    end else if (cmd_i.hold && is_pid) begin
      wv_d   = 1'b1;
      wres_d = cmd_i.res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_q <= 1'b1;
      wv_q   <= 1'b0;
      wres_q <= '0;
      tok_q  <= 1'b0;
    end else begin
      free_q <= free_d;
      wv_q   <= wv_d;
      wres_q <= wres_d;
      tok_q  <= tok_i;
    end
  end

endmodule

`default_nettype wire

[rtl/resource_lock_with_waiter_handoff_core.sv]
// top level of the lock manager core: controller, chain of cells, output register
// depends on rlwh_pkg and rlwh_cell
//
//   channel | valid      | stall        | payload
//   --------+------------+--------------+------------------------------------------
//   request | in_valid_i | in_stall_o   | cmd_i, resource_index_i, process_id_i
//   result  | out_valid_o| out_stall_i  | status_o, woke_valid_o, woke_process_o
//
// one request at a time; acquire, bad index and release of a free resource go from S_IDLE
// through S_EXEC and S_DONE back to S_IDLE before the next request is accepted
// a release of a held resource sends a token up the cell chain, one cell a cycle, in S_SCAN,
// until the lowest waiter claims it or, with no waiter, it runs off the end and frees the resource
// the result register lets a new request in while a result waits on out_stall_i
// reset: all resources free, no process waiting, no result pending
`default_nettype none

module resource_lock_with_waiter_handoff_core #(
  parameter int unsigned NUM_SLOTS = rlwh_pkg::NumSlotsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         cmd_i,
  input  logic [rlwh_pkg::ResW-1:0]    resource_index_i,
  input  logic [rlwh_pkg::PidW-1:0]    process_id_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [rlwh_pkg::StatusW-1:0] status_o,
  output logic                         woke_valid_o,
  output logic [rlwh_pkg::PidW-1:0]    woke_process_o
);
  import rlwh_pkg::*;

  // controller states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]         state_q, state_d;
  logic               req_cmd_q;
  logic [ResW-1:0]    req_res_q;
  logic [PidW-1:0]    req_pid_q;
  logic [StatusW-1:0] pend_st_q, pend_st_d;
  logic               pend_wv_q, pend_wv_d;
  logic [PidW-1:0]    pend_wp_q, pend_wp_d;
  logic               out_valid_q;
  logic [StatusW-1:0] out_st_q;
  logic               out_wv_q;
  logic [PidW-1:0]    out_wp_q;

  cell_cmd_t          ccmd;
  logic [NUM_SLOTS:0] tok;
  logic [NUM_SLOTS-1:0] hit_vec;
  logic [NUM_SLOTS-1:0] free_vec;
  logic [NUM_SLOTS-1:0] wait_vec;
  logic               start;
  logic               hit_any;
  logic               free_any;
  logic               wait_any;
  logic [PidW-1:0]    hit_idx;
  logic               bad;
  logic               in_acc;
  logic               out_load;

  // chain of cells, token travels from cell 0 upward
  assign tok[0] = start;

  for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
    rlwh_cell #(
      .CellIdx(i)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .cmd_i     (ccmd),
      .tok_i     (tok[i]),
      .tok_o     (tok[i+1]),
      .hit_o     (hit_vec[i]),
      .free_sel_o(free_vec[i]),
      .wait_sel_o(wait_vec[i])
    );
  end

  assign hit_any  = |hit_vec;
  assign free_any = |free_vec;
  assign wait_any = |wait_vec;

  // index of the cell holding the token on a hit
  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (hit_vec[i]) begin
        hit_idx = hit_idx | PidW'(i);
      end
    end
  end

  // range checks on the latched request
  assign bad = (32'(req_res_q) >= NUM_SLOTS) ||
               ((req_cmd_q == CMD_ACQUIRE) && (32'(req_pid_q) >= NUM_SLOTS));

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_load = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);

  // controller
  always_comb begin
    state_d   = state_q;
    pend_st_d = pend_st_q;
    pend_wv_d = pend_wv_q;
    pend_wp_d = pend_wp_q;
    start     = 1'b0;
    ccmd.take = 1'b0;
    ccmd.give = 1'b0;
    ccmd.hold = 1'b0;
    ccmd.res  = req_res_q;
    ccmd.pid  = req_pid_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        pend_wv_d = 1'b0;
        pend_wp_d = '0;
        state_d   = S_DONE;
        priority if (bad) begin
          pend_st_d = ST_BAD_INDEX;
        end else if (req_cmd_q == CMD_ACQUIRE) begin
          priority if (wait_any) begin
            pend_st_d = ST_REFUSED;
          end else if (free_any) begin
            ccmd.take = 1'b1;
            pend_st_d = ST_GRANTED;
          end else begin
            ccmd.hold = 1'b1;
            pend_st_d = ST_WAITING;
          end
        end else if (free_any) begin
          pend_st_d = ST_RELEASE_FREE;
        end else begin
          start   = 1'b1;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (hit_any) begin
          pend_st_d = ST_RELEASED;
          pend_wv_d = 1'b1;
          pend_wp_d = hit_idx;
          state_d   = S_DONE;
        end else if (tok[NUM_SLOTS]) begin
          // token ran off the end: nobody waits, resource becomes free
          ccmd.give = 1'b1;
          pend_st_d = ST_RELEASED;
          state_d   = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
    endcase
  end

  assign in_stall_o = (state_q != S_IDLE);

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // request, pending result and output payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_cmd_q <= cmd_i;
      req_res_q <= resource_index_i;
      req_pid_q <= process_id_i;
    end
    pend_st_q <= pend_st_d;
    pend_wv_q <= pend_wv_d;
    pend_wp_q <= pend_wp_d;
    if (out_load) begin
      out_st_q <= pend_st_q;
      out_wv_q <= pend_wv_q;
      out_wp_q <= pend_wp_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_st_q;
  assign woke_valid_o   = out_wv_q;
  assign woke_process_o = out_wp_q;

endmodule

`default_nettype wire

[rtl/rlwh_chk.sv]
// port checker of the lock manager core, attached to the top level by bind
// depends on rlwh_pkg and resource_lock_with_waiter_handoff_core_defines.svh
`include "resource_lock_with_waiter_handoff_core_defines.svh"
`default_nettype none

module rlwh_chk (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_stall_o,
  input  logic                         out_valid_o,
  input  logic                         out_stall_i,
  input  logic [rlwh_pkg::StatusW-1:0] status_o,
  input  logic                         woke_valid_o,
  input  logic [rlwh_pkg::PidW-1:0]    woke_process_o
);
  import rlwh_pkg::*;

  // a stalled result holds its status
  `RLWH_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o))

  // one request at a time: the port closes after each accepted transaction
  `RLWH_ASSERT(a_one_at_a_time, clk_i, rst_ni, in_valid_i && !in_stall_o |=> in_stall_o)

  // a hand-off is only ever reported with a release
  `RLWH_ASSERT_MSG(a_woke_status, clk_i, rst_ni, out_valid_o && woke_valid_o |-> status_o == ST_RELEASED, "hand-off without release status")

  // no hand-off means no process reported
  `RLWH_ASSERT_MSG(a_woke_zero, clk_i, rst_ni, out_valid_o && !woke_valid_o |-> woke_process_o == '0, "woken process without hand-off")

endmodule

bind resource_lock_with_waiter_handoff_core rlwh_chk u_rlwh_chk (.*);

`default_nettype wire

[sim/resource_lock_with_waiter_handoff_core_tb.sv]
// testbench of the lock manager core: directed table, then random acquire/release traffic
// depends on rlwh_pkg and resource_lock_with_waiter_handoff_core
// results are checked field by field: typed rows against the table, others against a lock-state predictor
`timescale 1ns / 100ps

module resource_lock_with_waiter_handoff_core_tb;
  import rlwh_pkg::*;

  localparam int unsigned NumSlots   = NumSlotsDef;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned DrainWait  = 40;
  localparam int unsigned PrintLimit = 60;

  // one result transaction
  typedef struct packed {
    logic [StatusW-1:0] status;
    logic               woke;
    logic [PidW-1:0]    woke_pid;
  } lock_result_t;

  // one row of the directed table
  typedef struct packed {
    logic            cmd;
    logic [ResW-1:0] res;
    logic [PidW-1:0] pid;
    logic            typed;
    lock_result_t    exp;
  } lock_row_t;

  logic               clk;
  logic               rst_n;
  logic               req_valid;
  logic               req_stall;
  logic               req_cmd;
  logic [ResW-1:0]    req_res;
  logic [PidW-1:0]    req_pid;
  logic               req_typed;
  lock_result_t       req_exp;
  logic               rsp_valid;
  logic               rsp_stall;
  logic [StatusW-1:0] rsp_status;
  logic               rsp_woke;
  logic [PidW-1:0]    rsp_woke_pid;

  // lock state mirrored by the predictor
  logic [NumSlots-1:0] res_free;
  logic [NumSlots-1:0] proc_waiting;
  logic [ResW-1:0]     wait_res [NumSlots];

  lock_result_t pending_results[$];
  lock_row_t    lock_rows[$];
  int unsigned  mismatches;
  int unsigned  cycle_count;
  int unsigned  stall_left;
  logic         idle_on;

  resource_lock_with_waiter_handoff_core i_dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (req_valid),
    .in_stall_o       (req_stall),
    .cmd_i            (req_cmd),
    .resource_index_i (req_res),
    .process_id_i     (req_pid),
    .out_valid_o      (rsp_valid),
    .out_stall_i      (rsp_stall),
    .status_o         (rsp_status),
    .woke_valid_o     (rsp_woke),
    .woke_process_o   (rsp_woke_pid)
  );

  // clock, 10 ns period
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    if (mismatches < PrintLimit) begin
      $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    end
    mismatches++;
  endtask

  task automatic reset_lock_state();
    res_free     = '1;
    proc_waiting = '0;
    for (int i = 0; i < NumSlots; i++) begin
      wait_res[i] = '0;
    end
  endtask

  // applies one request to the mirrored state and returns its result
  function automatic lock_result_t apply_lock_request(input logic c, input logic [ResW-1:0] r,
                                                      input logic [PidW-1:0] p);
    lock_result_t rsl;
    logic         found;
    rsl   = '0;
    found = 1'b0;
    if (int'(r) >= NumSlots) begin
      rsl.status = ST_BAD_INDEX;
    end else if (c == CMD_ACQUIRE) begin
      if (int'(p) >= NumSlots) begin
        rsl.status = ST_BAD_INDEX;
      end else if (proc_waiting[p]) begin
        rsl.status = ST_REFUSED;
      end else if (res_free[r]) begin
        res_free[r] = 1'b0;
        rsl.status  = ST_GRANTED;
      end else begin
        proc_waiting[p] = 1'b1;
        wait_res[p]     = r;
        rsl.status      = ST_WAITING;
      end
    end else if (res_free[r]) begin
      rsl.status = ST_RELEASE_FREE;
    end else begin
      rsl.status = ST_RELEASED;
      // hand-off goes to the lowest-numbered waiter
      for (int i = 0; i < NumSlots; i++) begin
        if (!found && proc_waiting[i] && wait_res[i] == r) begin
          proc_waiting[i] = 1'b0;
          rsl.woke        = 1'b1;
          rsl.woke_pid    = PidW'(i);
          found           = 1'b1;
        end
      end
      if (!found) begin
        res_free[r] = 1'b1;
      end
    end
    return rsl;
  endfunction

  // result check first, then prediction of the transaction accepted at this edge
  always @(posedge clk) begin
    if (rst_n === 1'b1 && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, status", rsp_status, 0);
      end else begin
        if (rsp_status !== pending_results[0].status) begin
          report_mismatch("status", rsp_status, pending_results[0].status);
        end
        if (rsp_woke !== pending_results[0].woke) begin
          report_mismatch("woke_valid", rsp_woke, pending_results[0].woke);
        end
        if (rsp_woke_pid !== pending_results[0].woke_pid) begin
          report_mismatch("woke_process", rsp_woke_pid, pending_results[0].woke_pid);
        end
        void'(pending_results.pop_front());
      end
    end
    if (rst_n === 1'b1 && req_valid === 1'b1 && req_stall === 1'b0) begin
      if (req_typed) begin
        void'(apply_lock_request(req_cmd, req_res, req_pid));
        pending_results.push_back(req_exp);
      end else begin
        pending_results.push_back(apply_lock_request(req_cmd, req_res, req_pid));
      end
    end
  end

  // result stall raised in random bursts while idle_on is set
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      rsp_stall  <= 1'b1;
      stall_left = $urandom_range(0, 6);
    end else begin
      rsp_stall <= 1'b0;
    end
  end

  // cycle limit
  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("resource_lock_with_waiter_handoff_core_tb: FAIL");
    $finish;
  end

  task automatic add_row(input logic c, input int unsigned r, input int unsigned p,
                         input logic typed, input logic [StatusW-1:0] st,
                         input logic woke, input int unsigned woke_pid);
    lock_row_t row;
    row.cmd          = c;
    row.res          = ResW'(r);
    row.pid          = PidW'(p);
    row.typed        = typed;
    row.exp.status   = st;
    row.exp.woke     = woke;
    row.exp.woke_pid = PidW'(woke_pid);
    lock_rows.push_back(row);
  endtask

  // drive one request and hold it until accepted
  task automatic send_lock_request(input logic c, input logic [ResW-1:0] r,
                                   input logic [PidW-1:0] p, input logic typed,
                                   input lock_result_t exp);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    req_valid <= 1'b1;
    req_cmd   <= c;
    req_res   <= r;
    req_pid   <= p;
    req_typed <= typed;
    req_exp   <= exp;
    @(posedge clk);
    while (req_stall !== 1'b0) @(posedge clk);
  endtask

  // random traffic: resources mostly from a small pool so waiters pile up
  task automatic send_random_request(input int unsigned pool, input int unsigned acq_pct);
    logic            c;
    logic [ResW-1:0] r;
    logic [PidW-1:0] p;
    c = ($urandom_range(1, 100) <= acq_pct) ? CMD_ACQUIRE : CMD_RELEASE;
    if ($urandom_range(0, 7) == 0) begin
      r = ResW'($urandom_range(0, NumSlots - 1));
    end else begin
      r = ResW'($urandom_range(0, pool - 1));
    end
    p = PidW'($urandom_range(0, NumSlots - 1));
    send_lock_request(c, r, p, 1'b0, '0);
  endtask

  task automatic wait_for_results();
    @(negedge clk);
    while (pending_results.size() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  // main sequence
  initial begin
    lock_row_t row;
    rst_n      = 1'b0;
    req_valid  = 1'b0;
    req_cmd    = CMD_ACQUIRE;
    req_res    = '0;
    req_pid    = '0;
    req_typed  = 1'b0;
    req_exp    = '0;
    rsp_stall  = 1'b0;
    stall_left = 0;
    idle_on    = 1'b1;
    mismatches = 0;
    reset_lock_state();

    // directed table; indices are 4 bits wide with 16 slots, so a bad index cannot occur
    add_row(CMD_ACQUIRE, 0, 0, 1'b1, ST_GRANTED, 1'b0, 0);
    add_row(CMD_ACQUIRE, 0, 1, 1'b1, ST_WAITING, 1'b0, 0);
    add_row(CMD_ACQUIRE, 0, 15, 1'b1, ST_WAITING, 1'b0, 0);
    // waiting process refused even though the resource is free
    add_row(CMD_ACQUIRE, 15, 1, 1'b1, ST_REFUSED, 1'b0, 0);
    add_row(CMD_RELEASE, 15, 0, 1'b1, ST_RELEASE_FREE, 1'b0, 0);
    add_row(CMD_ACQUIRE, 15, 15, 1'b1, ST_REFUSED, 1'b0, 0);
    add_row(CMD_ACQUIRE, 15, 14, 1'b1, ST_GRANTED, 1'b0, 0);
    add_row(CMD_RELEASE, 0, 15, 1'b1, ST_RELEASED, 1'b1, 1);
    add_row(CMD_RELEASE, 0, 0, 1'b0, ST_GRANTED, 1'b0, 0);
    add_row(CMD_RELEASE, 0, 0, 1'b0, ST_GRANTED, 1'b0, 0);
    add_row(CMD_RELEASE, 0, 7, 1'b1, ST_RELEASE_FREE, 1'b0, 0);
    add_row(CMD_ACQUIRE, 15, 0, 1'b0, ST_GRANTED, 1'b0, 0);
    add_row(CMD_RELEASE, 15, 9, 1'b0, ST_GRANTED, 1'b0, 0);
    add_row(CMD_RELEASE, 15, 0, 1'b0, ST_GRANTED, 1'b0, 0);
    add_row(CMD_ACQUIRE, 7, 8, 1'b0, ST_GRANTED, 1'b0, 0);
    add_row(CMD_ACQUIRE, 7, 15, 1'b0, ST_GRANTED, 1'b0, 0);
    add_row(CMD_ACQUIRE, 7, 3, 1'b0, ST_GRANTED, 1'b0, 0);
    add_row(CMD_ACQUIRE, 7, 10, 1'b0, ST_GRANTED, 1'b0, 0);
    add_row(CMD_RELEASE, 7, 6, 1'b0, ST_GRANTED, 1'b0, 0);
    add_row(CMD_RELEASE, 7, 6, 1'b0, ST_GRANTED, 1'b0, 0);
    add_row(CMD_RELEASE, 7, 6, 1'b0, ST_GRANTED, 1'b0, 0);
    add_row(CMD_RELEASE, 7, 6, 1'b0, ST_GRANTED, 1'b0, 0);
    add_row(CMD_ACQUIRE, 10, 5, 1'b0, ST_GRANTED, 1'b0, 0);
    add_row(CMD_RELEASE, 10, 10, 1'b0, ST_GRANTED, 1'b0, 0);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (lock_rows[i]) begin
      row = lock_rows[i];
      send_lock_request(row.cmd, row.res, row.pid, row.typed, row.exp);
    end

    // heavy contention on a few resources, idling switched per block
    for (int blk = 0; blk < 8; blk++) begin
      idle_on = ($urandom_range(0, 3) != 0);
      for (int i = 0; i < 40; i++) begin
        send_random_request(($urandom_range(0, 1) == 0) ? 2 : 4, 60);
      end
    end

    // hold the sender until every result is back
    req_valid <= 1'b0;
    wait_for_results();

    // wider spread of resources
    for (int blk = 0; blk < 8; blk++) begin
      idle_on = ($urandom_range(0, 3) != 0);
      for (int i = 0; i < 38; i++) begin
        send_random_request(NumSlots, 50);
      end
    end

    // closing part without idling
    idle_on = 1'b0;
    for (int i = 0; i < 226; i++) begin
      send_random_request(8, 55);
    end

    req_valid <= 1'b0;
    wait_for_results();
    repeat (DrainWait) @(posedge clk);
    if (pending_results.size() != 0) begin
      report_mismatch("results still expected", 0, pending_results.size());
    end

    if (mismatches == 0) begin
      $display("resource_lock_with_waiter_handoff_core_tb: PASS");
    end else begin
      $display("resource_lock_with_waiter_handoff_core_tb: FAIL");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+rtl
rtl/rlwh_pkg.sv
rtl/rlwh_cell.sv
rtl/resource_lock_with_waiter_handoff_core.sv
rtl/rlwh_chk.sv
sim/resource_lock_with_waiter_handoff_core_tb.sv
